// ===== src/cam_pkg.sv =====
`timescale 1ns / 1ps
// cam_pkg: shared types, register codes, fixed widths and the speed profile rom
// for the arm motion controller; no dependencies
package cam_pkg;

  // register indexes on the configuration port
  localparam int REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_HOME_POSITION   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_RAISED_POSITION = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_SPEED_CAP       = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_ARRIVE_WINDOW   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_SPEED_KP        = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_SPEED_KI        = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_SPEED_KD        = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_POSITION_KP     = 3'd7;

  localparam int CFG_DATA_W = 32;
  localparam int GAIN_W     = 24;

  // command codes
  localparam logic [1:0] CMD_RAISE = 2'd1;
  localparam logic [1:0] CMD_LOWER = 2'd2;

  typedef enum logic [1:0] {
    PH_HOLD_HOME   = 2'd0,
    PH_RAISING     = 2'd1,
    PH_HOLD_RAISED = 2'd2,
    PH_LOWERING    = 2'd3
  } phase_t;

  typedef struct packed {
    logic signed [31:0] home_position;
    logic signed [31:0] raised_position;
    logic [11:0]        speed_cap;
    logic [15:0]        arrive_window;
    logic [GAIN_W-1:0]  speed_kp;
    logic [GAIN_W-1:0]  speed_ki;
    logic [GAIN_W-1:0]  speed_kd;
    logic [GAIN_W-1:0]  position_kp;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    home_position:   32'sd0,
    raised_position: 32'sd13800,
    speed_cap:       12'd220,
    arrive_window:   16'd300,
    speed_kp:        24'd32768,
    speed_ki:        24'd98304,
    speed_kd:        24'd0,
    position_kp:     24'd524
  };

  // shared digit-serial multiplier: 32 x 24 bits, radix 16, q8.16 gains
  localparam int MUL_A_W    = 32;
  localparam int MUL_B_W    = GAIN_W;
  localparam int DIGIT_W    = 4;
  localparam int MUL_STEPS  = MUL_B_W / DIGIT_W;
  localparam int STEP_CNT_W = $clog2(MUL_STEPS + 1);
  localparam int PROD_W     = MUL_A_W + MUL_B_W;
  localparam int FRAC_W     = 16;
  localparam int MUL_HI_W   = PROD_W - FRAC_W;

  typedef struct packed {
    logic busy;
    logic done;
  } mul_status_t;

  // speed path widths
  localparam int SPEED_W          = 18;
  localparam int HOLD_W           = 15;
  localparam int HOLD_SPEED_LIMIT = 32767;
  localparam int ACCEL_BOOST      = 60;
  localparam int PROFILE_W        = 9;
  localparam int DRIVE_SUM_W      = 30;

  function automatic logic [PROFILE_W-1:0] profile_value(input logic [7:0] idx);
    logic [PROFILE_W-1:0] v;
    case (idx) inside
      8'd0:          v = 9'd0;
      8'd1:          v = 9'd291;
      [8'd2:8'd13]:  v = 9'd299;
      default:       v = 9'd300;
    endcase
    return v;
  endfunction

endpackage

// ===== src/cascaded_arm_motion_controller.sv =====
`timescale 1ns / 1ps
// cascaded_arm_motion_controller: position loop and motion profile over a speed pid
// depends on cam_pkg, cam_regs, cam_mul
//
//  channel  signals                               direction  beat
//  in       in_valid/in_ready                     sink       command, encoder_count
//  out      out_valid/out_ready                   source     compares, phase, done, position
//  cfg      cfg_valid/cfg_ready                   sink       cfg_index, cfg_data
//
// an item is accepted only while the sequencer is idle, so the next item waits until the
// result of the last one is registered; four multiplies go through the one radix-16
// multiplier in turn.
// synchronous reset returns the phase to hold home and clears position and pid state.
// a result waiting on out_ready does not stop the next input beat; the sequencer only
// waits at its last step while the output register is still full.
module cascaded_arm_motion_controller #(
  parameter int POSITION_WIDTH   = 32,
  parameter int PROFILE_ENTRIES  = 16,
  parameter int INTEGRAL_LIMIT   = 2000,
  parameter int DRIVE_LIMIT      = 2700,
  parameter int PWM_PERIOD       = 3000,
  parameter int ENCODER_MIDPOINT = 32767
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     command,
  input  logic [15:0]                    encoder_count,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [11:0]                    pwm_compare_a,
  output logic [11:0]                    pwm_compare_b,
  output logic [1:0]                     motion_phase,
  output logic                           raise_done,
  output logic                           lower_done,
  output logic signed [31:0]             position_now,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [cam_pkg::REG_IDX_W-1:0]  cfg_index,
  input  logic [cam_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int DW      = ((POSITION_WIDTH > 32) ? POSITION_WIDTH : 32) + 1;
  localparam int IDX_W   = $clog2(PROFILE_ENTRIES);
  localparam int INT_W   = $clog2(INTEGRAL_LIMIT + 1) + 1;
  localparam int ISUM_W  = ((INT_W > cam_pkg::SPEED_W) ? INT_W : cam_pkg::SPEED_W) + 1;
  localparam int DRIVE_W = $clog2(DRIVE_LIMIT + 1) + 1;
  localparam int CMP_W   = $clog2(PWM_PERIOD + 1) + 2;
  localparam int SW      = cam_pkg::SPEED_W;

  typedef enum logic [3:0] {
    S_IDLE, S_ACC, S_DIFF, S_ABS, S_MOVE, S_HOLD_MUL,
    S_INTEG, S_P_MUL, S_I_MUL, S_D_MUL, S_FINISH
  } state_t;

  cam_pkg::cfg_t        cfg;
  cam_pkg::mul_status_t mul_stat;
  cam_pkg::phase_t      phase;
  state_t               state;

  logic                             mul_start;
  logic [cam_pkg::MUL_A_W-1:0]      mul_a;
  logic [cam_pkg::MUL_B_W-1:0]      mul_b;
  logic [cam_pkg::MUL_HI_W-1:0]     mul_prod;

  logic signed [SW-1:0]             speed;
  logic signed [POSITION_WIDTH-1:0] pos;
  logic signed [DW-1:0]             pos_ext, dh, dr;
  logic [DW-1:0]                    ah, ar;
  logic                             raise_flag, lower_flag;
  logic                             use_hold, hold_neg;
  logic signed [SW-1:0]             move_tgt, err, prev_err;
  logic signed [INT_W-1:0]          integ;
  logic signed [SW:0]               dd;
  logic signed [cam_pkg::DRIVE_SUM_W-1:0] drv;

  // move stage
  logic                             raising, move_le, arrive;
  logic [DW-1:0]                    x1, x2, x_sel, hold_abs;
  logic [IDX_W-1:0]                 pidx;
  logic [cam_pkg::PROFILE_W-1:0]    rom_val;
  logic [9:0]                       prof_spd;
  logic [11:0]                      move_mag;
  logic [cam_pkg::MUL_A_W-1:0]      hold_mag;

  // pid stage
  logic [cam_pkg::HOLD_W-1:0]       hold_p;
  logic signed [SW-1:0]             hold_tgt, tgt, err_next;
  logic signed [ISUM_W-1:0]         isum;
  logic signed [INT_W-1:0]          integ_next;
  logic signed [SW:0]               dd_next;
  logic [SW-1:0]                    err_mag;
  logic [INT_W-1:0]                 integ_mag;
  logic [SW:0]                      dd_mag;
  logic signed [cam_pkg::DRIVE_SUM_W-1:0] term;
  logic                             term_neg;

  // output stage
  logic signed [DRIVE_W-1:0]        drive;
  logic signed [CMP_W-1:0]          cmp_a, cmp_b;

  cam_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  cam_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .mcand   (mul_a),
    .mplier  (mul_b),
    .prod_hi (mul_prod),
    .status  (mul_stat)
  );

  assign in_ready = (state == S_IDLE);
  assign pos_ext  = DW'(pos);

  always_comb begin
    raising  = (phase == cam_pkg::PH_RAISING);
    x1       = raising ? ah : ar;
    x2       = raising ? ar : ah;
    move_le  = (x1 <= x2);
    x_sel    = move_le ? x1 : x2;
    pidx     = (x_sel >= DW'(PROFILE_ENTRIES - 1)) ? IDX_W'(PROFILE_ENTRIES - 1)
                                                   : x_sel[IDX_W-1:0];
    rom_val  = cam_pkg::profile_value(8'(pidx));
    prof_spd = 10'(rom_val) + (move_le ? 10'(cam_pkg::ACCEL_BOOST) : 10'd0);
    move_mag = (12'(prof_spd) >= cfg.speed_cap) ? cfg.speed_cap : 12'(prof_spd);
    arrive   = raising ? (ar < DW'(cfg.arrive_window)) : (ah < DW'(cfg.arrive_window));
    hold_abs = (phase == cam_pkg::PH_HOLD_HOME) ? ah : ar;
    // beyond 2^31 the product saturates for any nonzero gain
    hold_mag = (hold_abs >= (DW'(1) << (cam_pkg::MUL_A_W - 1)))
             ? {1'b1, (cam_pkg::MUL_A_W - 1)'(0)} : hold_abs[cam_pkg::MUL_A_W-1:0];
  end

  always_comb begin
    hold_p     = (mul_prod > cam_pkg::MUL_HI_W'(cam_pkg::HOLD_SPEED_LIMIT))
               ? cam_pkg::HOLD_W'(cam_pkg::HOLD_SPEED_LIMIT) : mul_prod[cam_pkg::HOLD_W-1:0];
    hold_tgt   = hold_neg ? -$signed(SW'(hold_p)) : $signed(SW'(hold_p));
    tgt        = use_hold ? hold_tgt : move_tgt;
    err_next   = tgt - speed;
    isum       = ISUM_W'(integ) + ISUM_W'(err);
    if (isum > $signed(ISUM_W'(INTEGRAL_LIMIT)))
      integ_next = $signed(INT_W'(INTEGRAL_LIMIT));
    else if (isum < -$signed(ISUM_W'(INTEGRAL_LIMIT)))
      integ_next = -$signed(INT_W'(INTEGRAL_LIMIT));
    else
      integ_next = isum[INT_W-1:0];
    dd_next    = (SW + 1)'(err) - (SW + 1)'(prev_err);
    err_mag    = err[SW-1] ? $unsigned(-err) : $unsigned(err);
    integ_mag  = integ[INT_W-1] ? $unsigned(-integ) : $unsigned(integ);
    dd_mag     = dd[SW] ? $unsigned(-dd) : $unsigned(dd);
    term       = $signed({1'b0, mul_prod[cam_pkg::DRIVE_SUM_W-2:0]});
    case (state)
      S_P_MUL: term_neg = err[SW-1];
      S_I_MUL: term_neg = integ[INT_W-1];
      default: term_neg = dd[SW];
    endcase
  end

  always_comb begin
    if (drv > $signed(cam_pkg::DRIVE_SUM_W'(DRIVE_LIMIT)))
      drive = $signed(DRIVE_W'(DRIVE_LIMIT));
    else if (drv < -$signed(cam_pkg::DRIVE_SUM_W'(DRIVE_LIMIT)))
      drive = -$signed(DRIVE_W'(DRIVE_LIMIT));
    else
      drive = drv[DRIVE_W-1:0];
    cmp_a = $signed(CMP_W'(PWM_PERIOD));
    cmp_b = $signed(CMP_W'(PWM_PERIOD));
    if (drive >= 0)
      cmp_a = $signed(CMP_W'(PWM_PERIOD)) - CMP_W'(drive);
    else
      cmp_b = $signed(CMP_W'(PWM_PERIOD)) + CMP_W'(drive);
    if (cmp_a < 0) cmp_a = '0;
    if (cmp_b < 0) cmp_b = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      phase     <= cam_pkg::PH_HOLD_HOME;
      pos       <= '0;
      integ     <= '0;
      prev_err  <= '0;
      out_valid <= 1'b0;
      mul_start <= 1'b0;
    end else begin
      mul_start <= 1'b0;
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            speed      <= SW'(encoder_count) - SW'(ENCODER_MIDPOINT);
            raise_flag <= 1'b0;
            lower_flag <= 1'b0;
            case (command)
              cam_pkg::CMD_RAISE: phase <= cam_pkg::PH_RAISING;
              cam_pkg::CMD_LOWER: phase <= cam_pkg::PH_LOWERING;
              default: ;
            endcase
            state <= S_ACC;
          end
        end
        S_ACC: begin
          pos   <= pos + POSITION_WIDTH'(speed);
          state <= S_DIFF;
        end
        S_DIFF: begin
          dh    <= DW'(cfg.home_position) - pos_ext;
          dr    <= DW'(cfg.raised_position) - pos_ext;
          state <= S_ABS;
        end
        S_ABS: begin
          ah    <= dh[DW-1] ? $unsigned(-dh) : $unsigned(dh);
          ar    <= dr[DW-1] ? $unsigned(-dr) : $unsigned(dr);
          state <= S_MOVE;
        end
        S_MOVE: begin
          use_hold  <= (phase == cam_pkg::PH_HOLD_HOME) || (phase == cam_pkg::PH_HOLD_RAISED);
          hold_neg  <= (phase == cam_pkg::PH_HOLD_HOME) ? dh[DW-1] : dr[DW-1];
          move_tgt  <= raising ? $signed(SW'(move_mag)) : -$signed(SW'(move_mag));
          if (phase == cam_pkg::PH_RAISING && arrive) begin
            phase      <= cam_pkg::PH_HOLD_RAISED;
            raise_flag <= 1'b1;
          end else if (phase == cam_pkg::PH_LOWERING && arrive) begin
            phase      <= cam_pkg::PH_HOLD_HOME;
            lower_flag <= 1'b1;
          end
          mul_start <= 1'b1;
          mul_a     <= hold_mag;
          mul_b     <= cfg.position_kp;
          state     <= S_HOLD_MUL;
        end
        S_HOLD_MUL: begin
          if (mul_stat.done) begin
            err   <= err_next;
            state <= S_INTEG;
          end
        end
        S_INTEG: begin
          integ     <= integ_next;
          dd        <= dd_next;
          prev_err  <= err;
          drv       <= '0;
          mul_start <= 1'b1;
          mul_a     <= cam_pkg::MUL_A_W'(err_mag);
          mul_b     <= cfg.speed_kp;
          state     <= S_P_MUL;
        end
        S_P_MUL: begin
          if (mul_stat.done) begin
            drv       <= term_neg ? drv - term : drv + term;
            mul_start <= 1'b1;
            mul_a     <= cam_pkg::MUL_A_W'(integ_mag);
            mul_b     <= cfg.speed_ki;
            state     <= S_I_MUL;
          end
        end
        S_I_MUL: begin
          if (mul_stat.done) begin
            drv       <= term_neg ? drv - term : drv + term;
            mul_start <= 1'b1;
            mul_a     <= cam_pkg::MUL_A_W'(dd_mag);
            mul_b     <= cfg.speed_kd;
            state     <= S_D_MUL;
          end
        end
        S_D_MUL: begin
          if (mul_stat.done) begin
            drv   <= term_neg ? drv - term : drv + term;
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (!out_valid || out_ready) begin
            out_valid     <= 1'b1;
            pwm_compare_a <= 12'($unsigned(cmp_a));
            pwm_compare_b <= 12'($unsigned(cmp_b));
            motion_phase  <= phase;
            raise_done    <= raise_flag;
            lower_done    <= lower_flag;
            position_now  <= pos_ext[31:0];
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_reset_clears_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");
  a_busy_after_beat: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready while an item is in work");
  a_mul_idle_at_beat: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |-> !mul_stat.busy)
    else $error("multiplier busy at input beat");
  a_done_phase: assert property (@(posedge clk) disable iff (rst)
    out_valid && (raise_done || lower_done) |->
      (raise_done && !lower_done && motion_phase == 2'(cam_pkg::PH_HOLD_RAISED)) ||
      (lower_done && !raise_done && motion_phase == 2'(cam_pkg::PH_HOLD_HOME)))
    else $error("done pulse does not match the phase");
`endif

endmodule

// ===== src/cam_mul.sv =====
`timescale 1ns / 1ps
// cam_mul: radix-16 digit-serial unsigned multiplier, one gain digit per cycle
// depends on cam_pkg
module cam_mul (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  input  logic [cam_pkg::MUL_A_W-1:0]            mcand,
  input  logic [cam_pkg::MUL_B_W-1:0]            mplier,
  output logic [cam_pkg::MUL_HI_W-1:0]           prod_hi,
  output cam_pkg::mul_status_t                   status
);

  localparam int PART_W = cam_pkg::MUL_A_W + cam_pkg::DIGIT_W;

  logic [cam_pkg::PROD_W-1:0]     acc;
  logic [cam_pkg::MUL_A_W-1:0]    a;
  logic [cam_pkg::MUL_B_W-1:0]    b;
  logic [cam_pkg::STEP_CNT_W-1:0] cnt;
  logic [PART_W-1:0]              partial;

  assign partial = PART_W'(a) *
                   PART_W'(b[cam_pkg::MUL_B_W-1 -: cam_pkg::DIGIT_W]);
  assign prod_hi = acc[cam_pkg::PROD_W-1:cam_pkg::FRAC_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      status <= '0;
      cnt    <= '0;
    end else begin
      status.done <= 1'b0;
      if (start) begin
        acc         <= '0;
        a           <= mcand;
        b           <= mplier;
        cnt         <= cam_pkg::STEP_CNT_W'(cam_pkg::MUL_STEPS);
        status.busy <= 1'b1;
      end else if (status.busy) begin
        // msb digit first: shift the sum up one digit and add the partial
        acc <= {acc[cam_pkg::PROD_W-cam_pkg::DIGIT_W-1:0], cam_pkg::DIGIT_W'(0)} +
               cam_pkg::PROD_W'(partial);
        b   <= b << cam_pkg::DIGIT_W;
        cnt <= cnt - cam_pkg::STEP_CNT_W'(1);
        if (cnt == cam_pkg::STEP_CNT_W'(1)) begin
          status.busy <= 1'b0;
          status.done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== src/cam_regs.sv =====
`timescale 1ns / 1ps
// cam_regs: configuration register file with its reset values
// depends on cam_pkg
module cam_regs (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [cam_pkg::REG_IDX_W-1:0]     cfg_index,
  input  logic [cam_pkg::CFG_DATA_W-1:0]    cfg_data,
  output cam_pkg::cfg_t                     cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= cam_pkg::CFG_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        cam_pkg::REG_HOME_POSITION:   cfg.home_position   <= cfg_data;
        cam_pkg::REG_RAISED_POSITION: cfg.raised_position <= cfg_data;
        cam_pkg::REG_SPEED_CAP:       cfg.speed_cap       <= cfg_data[11:0];
        cam_pkg::REG_ARRIVE_WINDOW:   cfg.arrive_window   <= cfg_data[15:0];
        cam_pkg::REG_SPEED_KP:        cfg.speed_kp        <= cfg_data[cam_pkg::GAIN_W-1:0];
        cam_pkg::REG_SPEED_KI:        cfg.speed_ki        <= cfg_data[cam_pkg::GAIN_W-1:0];
        cam_pkg::REG_SPEED_KD:        cfg.speed_kd        <= cfg_data[cam_pkg::GAIN_W-1:0];
        cam_pkg::REG_POSITION_KP:     cfg.position_kp     <= cfg_data[cam_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// tb_top: self-checking bench for cascaded_arm_motion_controller, driving control ticks
// and register writes and checking every result beat against an in-bench predictor
// depends on cam_pkg and the controller rtl
module tb_top;
  import cam_pkg::*;

  localparam int MIDPOINT      = 32767;
  localparam int INTEGRAL_CAP  = 2000;
  localparam int DRIVE_CAP     = 2700;
  localparam int PWM_PERIOD    = 3000;
  localparam int PROFILE_LAST  = 15;
  localparam int BATCH_ITEMS   = 215;
  localparam int SETTLE_CYCLES = 60;
  localparam int STALL_LIMIT   = 2000;
  localparam int unsigned GAIN_MAX = 24'hFFFFFF;
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_SPARE = 2'd3;

  localparam cfg_t SETTINGS_AFTER_RESET = '{
    home_position:   32'sd0,
    raised_position: 32'sd13800,
    speed_cap:       12'd220,
    arrive_window:   16'd300,
    speed_kp:        24'd32768,
    speed_ki:        24'd98304,
    speed_kd:        24'd0,
    position_kp:     24'd524
  };

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] enc;
  } tick_stim_t;

  typedef struct packed {
    logic [11:0]        cmp_a;
    logic [11:0]        cmp_b;
    phase_t             phase;
    logic               raise_done;
    logic               lower_done;
    logic signed [31:0] pos;
  } tick_outcome_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [1:0]            command = 2'd0;
  logic [15:0]           encoder_count = 16'd0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [11:0]           pwm_compare_a;
  logic [11:0]           pwm_compare_b;
  logic [1:0]            motion_phase;
  logic                  raise_done;
  logic                  lower_done;
  logic signed [31:0]    position_now;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [REG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  tick_stim_t    tick_queue[$];
  tick_outcome_t tick_outcomes[$];

  // predictor state
  cfg_t   arm_cfg = SETTINGS_AFTER_RESET;
  int     arm_pos = 0;
  phase_t arm_phase = PH_HOLD_HOME;
  longint arm_integral = 0;
  longint arm_prev_err = 0;

  int  stim_pos = 0;
  int  items_pushed = 0;
  int  mismatches = 0;
  int  quiet_cycles = 0;
  int  in_hold = 0;
  int  out_hold = 0;
  bit  in_calm = 1'b0;
  bit  out_calm = 1'b0;
  logic in_beat = 1'b0;
  logic out_beat = 1'b0;

  cascaded_arm_motion_controller dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .command       (command),
    .encoder_count (encoder_count),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .pwm_compare_a (pwm_compare_a),
    .pwm_compare_b (pwm_compare_b),
    .motion_phase  (motion_phase),
    .raise_done    (raise_done),
    .lower_done    (lower_done),
    .position_now  (position_now),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  end

  function automatic longint gap_between(input longint a, input longint b);
    return (a >= b) ? a - b : b - a;
  endfunction

  function automatic longint q16_scale(input longint a, input longint k);
    longint m;
    longint p;
    m = (a < 0) ? -a : a;
    p = (m * k) >>> 16;
    return (a < 0) ? -p : p;
  endfunction

  function automatic longint profile_speed(input longint x);
    if (x == 0) return 0;
    if (x == 1) return 291;
    if (x <= 13) return 299;
    return 300;
  endfunction

  function automatic longint hold_target(input longint goal, input longint pos);
    longint e;
    longint m;
    longint p;
    e = goal - pos;
    m = (e < 0) ? -e : e;
    if (arm_cfg.position_kp == '0) return 0;
    if (m >= 64'sd2147483648) p = HOLD_SPEED_LIMIT;
    else begin
      p = (m * longint'(arm_cfg.position_kp)) >>> 16;
      if (p > HOLD_SPEED_LIMIT) p = HOLD_SPEED_LIMIT;
    end
    return (e < 0) ? -p : p;
  endfunction

  function automatic longint move_target(input longint from, input longint to,
                                         input longint pos);
    longint x1;
    longint x2;
    longint s;
    x1 = gap_between(pos, from);
    x2 = gap_between(to, pos);
    if (x1 <= x2) s = profile_speed((x1 > PROFILE_LAST) ? PROFILE_LAST : x1) + ACCEL_BOOST;
    else s = profile_speed((x2 > PROFILE_LAST) ? PROFILE_LAST : x2);
    if (s >= longint'(arm_cfg.speed_cap)) s = longint'(arm_cfg.speed_cap);
    return s;
  endfunction

  // one control tick of the controller, updating the predictor state
  function automatic tick_outcome_t advance_arm(input logic [1:0] cmd,
                                                input logic [15:0] enc);
    tick_outcome_t o;
    longint spd;
    longint pos;
    longint home;
    longint raised;
    longint win;
    longint target;
    longint err;
    longint drive;
    home = longint'(arm_cfg.home_position);
    raised = longint'(arm_cfg.raised_position);
    win = longint'(arm_cfg.arrive_window);
    o.raise_done = 1'b0;
    o.lower_done = 1'b0;
    if (cmd == CMD_RAISE) arm_phase = PH_RAISING;
    else if (cmd == CMD_LOWER) arm_phase = PH_LOWERING;
    spd = longint'(enc) - MIDPOINT;
    arm_pos = arm_pos + int'(spd);
    pos = longint'(arm_pos);
    case (arm_phase)
      PH_HOLD_HOME: target = hold_target(home, pos);
      PH_RAISING: begin
        target = move_target(home, raised, pos);
        if (gap_between(raised, pos) < win) begin
          arm_phase = PH_HOLD_RAISED;
          o.raise_done = 1'b1;
        end
      end
      PH_HOLD_RAISED: target = hold_target(raised, pos);
      default: begin
        target = -move_target(raised, home, pos);
        if (gap_between(home, pos) < win) begin
          arm_phase = PH_HOLD_HOME;
          o.lower_done = 1'b1;
        end
      end
    endcase
    err = target - spd;
    arm_integral = arm_integral + err;
    if (arm_integral > INTEGRAL_CAP) arm_integral = INTEGRAL_CAP;
    if (arm_integral < -INTEGRAL_CAP) arm_integral = -INTEGRAL_CAP;
    drive = q16_scale(err, longint'(arm_cfg.speed_kp))
          + q16_scale(arm_integral, longint'(arm_cfg.speed_ki))
          + q16_scale(err - arm_prev_err, longint'(arm_cfg.speed_kd));
    arm_prev_err = err;
    if (drive > DRIVE_CAP) drive = DRIVE_CAP;
    if (drive < -DRIVE_CAP) drive = -DRIVE_CAP;
    o.cmp_a = (drive >= 0) ? 12'(PWM_PERIOD - drive) : 12'(PWM_PERIOD);
    o.cmp_b = (drive < 0) ? 12'(PWM_PERIOD + drive) : 12'(PWM_PERIOD);
    o.phase = arm_phase;
    o.pos = arm_pos;
    return o;
  endfunction

  function automatic int draw_wait(inout bit calm);
    if ($urandom_range(0, 39) == 0) calm = !calm;
    return calm ? 0 : int'($urandom_range(0, 4));
  endfunction

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $display("%0d ns: %s expected %0d got %0d", $time, name, $signed(want), $signed(got));
      mismatches++;
    end
  endtask

  // tick beat driver
  always @(negedge clk) begin
    tick_stim_t t;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_beat) begin
      if (in_valid) in_hold = draw_wait(in_calm);
      if (in_hold == 0 && tick_queue.size() != 0) begin
        t = tick_queue.pop_front();
        in_valid <= 1'b1;
        command <= t.cmd;
        encoder_count <= t.enc;
      end else begin
        in_valid <= 1'b0;
        if (in_hold != 0) in_hold = in_hold - 1;
      end
    end
  end

  // result back-pressure
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_beat) out_hold = draw_wait(out_calm);
      if (out_hold != 0) begin
        out_ready <= 1'b0;
        out_hold = out_hold - 1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // monitor, predictor and watchdog
  always @(posedge clk) begin
    tick_outcome_t want;
    if (rst) begin
      in_beat <= 1'b0;
      out_beat <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      in_beat <= in_valid && in_ready;
      out_beat <= out_valid && out_ready;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_HOME_POSITION:   arm_cfg.home_position = cfg_data;
          REG_RAISED_POSITION: arm_cfg.raised_position = cfg_data;
          REG_SPEED_CAP:       arm_cfg.speed_cap = cfg_data[11:0];
          REG_ARRIVE_WINDOW:   arm_cfg.arrive_window = cfg_data[15:0];
          REG_SPEED_KP:        arm_cfg.speed_kp = cfg_data[GAIN_W-1:0];
          REG_SPEED_KI:        arm_cfg.speed_ki = cfg_data[GAIN_W-1:0];
          REG_SPEED_KD:        arm_cfg.speed_kd = cfg_data[GAIN_W-1:0];
          default:             arm_cfg.position_kp = cfg_data[GAIN_W-1:0];
        endcase
      end
      if (in_valid && in_ready) tick_outcomes.push_back(advance_arm(command, encoder_count));
      if (out_valid && out_ready) begin
        if (tick_outcomes.size() == 0) begin
          $display("%0d ns: result beat expected none got phase %0d position %0d",
                   $time, motion_phase, position_now);
          mismatches++;
        end else begin
          want = tick_outcomes.pop_front();
          check_field("pwm_compare_a", want.cmp_a, pwm_compare_a);
          check_field("pwm_compare_b", want.cmp_b, pwm_compare_b);
          check_field("motion_phase", want.phase, motion_phase);
          check_field("raise_done", want.raise_done, raise_done);
          check_field("lower_done", want.lower_done, lower_done);
          check_field("position_now", {{32{want.pos[31]}}, want.pos},
                      {{32{position_now[31]}}, position_now});
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("cascaded_arm_motion_controller: mismatch");
        $finish;
      end
    end
  end

  task automatic push_tick(input logic [1:0] cmd, input int spd);
    tick_stim_t t;
    t.cmd = cmd;
    t.enc = 16'(spd + MIDPOINT);
    tick_queue.push_back(t);
    stim_pos = stim_pos + spd;
    items_pushed++;
  endtask

  function automatic logic [1:0] idle_cmd();
    return ($urandom_range(0, 7) == 0) ? CMD_SPARE : CMD_TICK;
  endfunction

  // a move toward goal, landing inside the window unless cut short or knocked off course
  task automatic steer_to(input logic [1:0] start_cmd, input int goal);
    logic [1:0] c;
    longint gap;
    longint spd;
    longint off;
    longint win;
    longint lim;
    longint span;
    int budget;
    c = start_cmd;
    win = longint'(arm_cfg.arrive_window);
    budget = ($urandom_range(0, 4) == 0) ? int'($urandom_range(1, 3)) : 40;
    for (int n = 0; n < budget; n++) begin
      gap = longint'(goal) - longint'(stim_pos);
      if ($urandom_range(0, 3) == 0) lim = $urandom_range(0, 20);
      else lim = $urandom_range(100, 32767);
      if ($urandom_range(0, 11) == 0) begin
        spd = longint'($urandom_range(0, 65535)) - MIDPOINT;
      end else if (gap <= lim && gap >= -lim) begin
        off = 0;
        if (win > 1) begin
          span = ($urandom_range(0, 1) == 0) ? 15 : win - 1;
          if (span > win - 1) span = win - 1;
          off = $urandom_range(0, int'(span));
          if ($urandom_range(0, 1) == 1) off = -off;
        end
        spd = gap + off;
      end else begin
        spd = (gap > 0) ? lim : -lim;
      end
      if (spd > 32768) spd = 32768;
      if (spd < -32767) spd = -32767;
      push_tick(c, int'(spd));
      c = idle_cmd();
      if (gap_between(longint'(goal), longint'(stim_pos)) < win) break;
    end
  endtask

  task automatic wander(input int count);
    int first;
    int r;
    first = items_pushed;
    while (items_pushed - first < count) begin
      r = $urandom_range(0, 99);
      if (r < 35) steer_to(CMD_RAISE, arm_cfg.raised_position);
      else if (r < 70) steer_to(CMD_LOWER, arm_cfg.home_position);
      else if (r < 85)
        repeat ($urandom_range(1, 6)) push_tick(idle_cmd(), int'($urandom_range(0, 1200)) - 600);
      else
        repeat ($urandom_range(1, 4))
          push_tick(2'($urandom_range(0, 3)), int'($urandom_range(0, 65535)) - MIDPOINT);
    end
  endtask

  function automatic int unsigned pick_level(input int unsigned top, input int unsigned usual);
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return top;
      default: return $urandom_range(0, usual);
    endcase
  endfunction

  function automatic cfg_t pick_settings();
    cfg_t c;
    int base;
    base = int'($urandom_range(0, 60000)) - 30000;
    c.home_position = base;
    if ($urandom_range(0, 1) == 0) c.raised_position = base + int'($urandom_range(1000, 30000));
    else c.raised_position = base - int'($urandom_range(1000, 30000));
    if ($urandom_range(0, 7) == 0) c.raised_position = $urandom;
    c.speed_cap = 12'(pick_level(4095, 700));
    c.arrive_window = 16'(pick_level(65535, 2500));
    c.speed_kp = 24'(pick_level(GAIN_MAX, 1 << 18));
    c.speed_ki = 24'(pick_level(GAIN_MAX, 1 << 18));
    c.speed_kd = 24'(pick_level(GAIN_MAX, 1 << 17));
    c.position_kp = 24'(pick_level(GAIN_MAX, 1 << 14));
    return c;
  endfunction

  task automatic cfg_write(input logic [REG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
  endtask

  // unused upper bits of the narrow registers carry junk
  task automatic program_settings(input cfg_t c);
    cfg_write(REG_HOME_POSITION, c.home_position);
    cfg_write(REG_RAISED_POSITION, c.raised_position);
    cfg_write(REG_SPEED_CAP, {20'($urandom), c.speed_cap});
    cfg_write(REG_ARRIVE_WINDOW, {16'($urandom), c.arrive_window});
    cfg_write(REG_SPEED_KP, {8'($urandom), c.speed_kp});
    cfg_write(REG_SPEED_KI, {8'($urandom), c.speed_ki});
    cfg_write(REG_SPEED_KD, {8'($urandom), c.speed_kd});
    cfg_write(REG_POSITION_KP, {8'($urandom), c.position_kp});
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (tick_queue.size() != 0 || in_valid || tick_outcomes.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin
    cfg_t s;
    // encoder extremes and the unused command code, from rest
    push_tick(CMD_TICK, 0);
    push_tick(CMD_TICK, 32768);
    push_tick(CMD_TICK, -32767);
    push_tick(CMD_SPARE, -1);
    // raise from home, boost at zero distance, arrival near the goal
    push_tick(CMD_RAISE, 0);
    push_tick(CMD_TICK, 1);
    push_tick(CMD_TICK, 6000);
    push_tick(CMD_TICK, 7790);
    push_tick(CMD_TICK, 9);
    push_tick(CMD_TICK, 400);
    // lower that arrives in one tick
    push_tick(CMD_LOWER, -14199);
    push_tick(CMD_TICK, 0);
    // moves broken off by the opposite command
    push_tick(CMD_RAISE, 5000);
    push_tick(CMD_LOWER, -2000);
    push_tick(CMD_RAISE, 1000);
    push_tick(CMD_SPARE, 20000);
    push_tick(CMD_TICK, -10000);
    push_tick(CMD_RAISE, 0);
    // overshoot past home, then exactly on and just inside the window
    push_tick(CMD_LOWER, -32767);
    push_tick(CMD_TICK, 18466);
    push_tick(CMD_TICK, 599);
    push_tick(CMD_TICK, 32768);
    wander(BATCH_ITEMS);
    drain();
    for (int p = 1; p <= 8; p++) begin
      case (p)
        2: s = '{home_position: 32'sh80000000, raised_position: 32'sh7FFFFFFF,
                 speed_cap: 12'hFFF, arrive_window: 16'hFFFF, speed_kp: 24'hFFFFFF,
                 speed_ki: 24'hFFFFFF, speed_kd: 24'hFFFFFF, position_kp: 24'hFFFFFF};
        3: s = '{home_position: 32'sd0, raised_position: -32'sd20000,
                 speed_cap: 12'd0, arrive_window: 16'd0, speed_kp: 24'd0,
                 speed_ki: 24'hFFFFFF, speed_kd: 24'd0, position_kp: 24'd0};
        default: s = pick_settings();
      endcase
      program_settings(s);
      wander(BATCH_ITEMS);
      drain();
    end
    if (mismatches == 0)
      $display("cascaded_arm_motion_controller: match");
    else
      $display("cascaded_arm_motion_controller: mismatch");
    $finish;
  end

endmodule
